FILE: sv/ffa_pkg.sv
// Shared constants, codes and controller/datapath command types for the allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;

    localparam int FFA_MAX_SEGMENTS   = 64;
    localparam int FFA_HEADER_BYTES   = 24;
    localparam int FFA_POOL_ADDR_BITS = 20;

    localparam int FFA_SIZE_W  = 21;
    localparam int FFA_ADDR_W  = 32;
    localparam int FFA_STAT_W  = 2;
    localparam int FFA_CIDX_W  = 1;
    localparam int FFA_CDATA_W = 32;

    localparam logic FFA_MODE_ALLOC = 1'b0;
    localparam logic FFA_MODE_FREE  = 1'b1;

    localparam logic [FFA_STAT_W-1:0] FFA_ST_OK       = 2'd0;
    localparam logic [FFA_STAT_W-1:0] FFA_ST_NO_FIT   = 2'd1;
    localparam logic [FFA_STAT_W-1:0] FFA_ST_BAD_ADDR = 2'd2;

    localparam logic [FFA_CIDX_W-1:0] FFA_REG_POOL_BASE  = 1'd0;
    localparam logic [FFA_CIDX_W-1:0] FFA_REG_POOL_BYTES = 1'd1;

    localparam logic [2:0] FFA_RD_I   = 3'd0;
    localparam logic [2:0] FFA_RD_IP1 = 3'd1;
    localparam logic [2:0] FFA_RD_IM1 = 3'd2;
    localparam logic [2:0] FFA_RD_JM1 = 3'd3;
    localparam logic [2:0] FFA_RD_JP1 = 3'd4;

    localparam logic [2:0] FFA_WR_NONE  = 3'd0;
    localparam logic [2:0] FFA_WR_J     = 3'd1;
    localparam logic [2:0] FFA_WR_SPLIT = 3'd2;
    localparam logic [2:0] FFA_WR_ALLOC = 3'd3;
    localparam logic [2:0] FFA_WR_FREE  = 3'd4;
    localparam logic [2:0] FFA_WR_PREV  = 3'd5;

    localparam logic [2:0] FFA_J_HOLD = 3'd0;
    localparam logic [2:0] FFA_J_CNT  = 3'd1;
    localparam logic [2:0] FFA_J_IP1  = 3'd2;
    localparam logic [2:0] FFA_J_I    = 3'd3;
    localparam logic [2:0] FFA_J_DEC  = 3'd4;
    localparam logic [2:0] FFA_J_INC  = 3'd5;

    typedef struct packed {
        logic                  load;
        logic                  rd_en;
        logic [2:0]            rd_sel;
        logic [2:0]            wr_sel;
        logic                  cap_cur;
        logic                  cap_nb;
        logic                  merge;
        logic                  i_inc;
        logic [2:0]            j_op;
        logic                  cnt_dec;
        logic                  done;
        logic [FFA_STAT_W-1:0] done_st;
    } ffa_cmd_t;

    typedef struct packed {
        logic mode;
        logic req_zero;
        logic cnt_zero;
        logic hit;
        logic split;
        logic i_last;
        logic i_gt0;
        logic ip1_lt_cnt;
        logic j_gt_ip1;
        logic jp1_lt_cnt;
        logic rd_free;
        logic out_free;
    } ffa_sts_t;

endpackage
`default_nettype wire

FILE: sv/ffa_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface ffa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [ffa_pkg::FFA_SIZE_W-1:0] req_size;
    logic [ffa_pkg::FFA_ADDR_W-1:0] free_address;
    modport source (output valid, mode, req_size, free_address, input ready);
    modport sink   (input valid, mode, req_size, free_address, output ready);
endinterface

interface ffa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ffa_pkg::FFA_ADDR_W-1:0] result_address;
    logic [ffa_pkg::FFA_STAT_W-1:0] status;
    modport source (output valid, result_address, status, input ready);
    modport sink   (input valid, result_address, status, output ready);
endinterface

interface ffa_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ffa_pkg::FFA_CIDX_W-1:0]  index;
    logic [ffa_pkg::FFA_CDATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: sv/ffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

FILE: sv/ffa_datapath.sv
// Segment table, index counters, merge/split arithmetic and result register.
`timescale 1ns / 1ps
`default_nettype none
module ffa_datapath #(
    parameter int MAX_SEGMENTS   = 64,
    parameter int HEADER_BYTES   = 24,
    parameter int POOL_ADDR_BITS = 20
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_mode,
    input  wire logic [ffa_pkg::FFA_SIZE_W-1:0]    in_req_size,
    input  wire logic [ffa_pkg::FFA_ADDR_W-1:0]    in_free_address,
    input  wire logic                              cfg_we,
    input  wire logic [ffa_pkg::FFA_CIDX_W-1:0]    cfg_index,
    input  wire logic [ffa_pkg::FFA_CDATA_W-1:0]   cfg_data,
    input  wire ffa_pkg::ffa_cmd_t                 cmd,
    output ffa_pkg::ffa_sts_t                      sts,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [ffa_pkg::FFA_ADDR_W-1:0]         out_result_address,
    output logic [ffa_pkg::FFA_STAT_W-1:0]         out_status
);
    import ffa_pkg::*;

    localparam int AW = POOL_ADDR_BITS;
    localparam int SW = POOL_ADDR_BITS + 1;
    localparam int CW = ((SW > FFA_SIZE_W) ? SW : FFA_SIZE_W) + 2;
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int NW = $clog2(MAX_SEGMENTS + 1);
    localparam int EW = AW + SW + 1;

    logic [FFA_ADDR_W-1:0] base_reg;
    logic [NW-1:0]         cnt_reg, cnt_next;
    logic [NW-1:0]         i_reg, j_reg;
    logic                  mode_reg;
    logic [FFA_SIZE_W-1:0] req_reg;
    logic [FFA_ADDR_W-1:0] off_reg;
    logic [AW-1:0]         cur_start_reg, nb_start_reg;
    logic [SW-1:0]         cur_size_reg, nb_size_reg;
    logic                  res_valid_reg;
    logic [FFA_ADDR_W-1:0] res_addr_reg;
    logic [FFA_STAT_W-1:0] res_st_reg;

    logic [EW-1:0] rdata, wdata;
    logic          we;
    logic [NW-1:0] rd_full, wr_full;
    logic [AW-1:0] r_start;
    logic [SW-1:0] r_size;
    logic          r_used;
    logic          split;
    logic [CW-1:0] hdr, bytes_x, bytes_sat, lim;
    logic          init_we;

    assign hdr     = CW'(HEADER_BYTES);
    assign r_start = rdata[EW-1 -: AW];
    assign r_size  = rdata[SW:1];
    assign r_used  = rdata[0];

    assign split = (CW'(cur_size_reg) > CW'(req_reg) + hdr) && (cnt_reg < NW'(MAX_SEGMENTS));

    // pool re-initialization from a pool_bytes write
    assign lim       = CW'(1) << AW;
    assign bytes_x   = CW'(cfg_data[FFA_SIZE_W-1:0]);
    assign bytes_sat = (bytes_x > lim) ? lim : bytes_x;
    assign init_we   = cfg_we && (cfg_index == FFA_REG_POOL_BYTES);

    always_comb
    begin
        case (cmd.rd_sel)
            FFA_RD_I:   rd_full = i_reg;
            FFA_RD_IP1: rd_full = i_reg + NW'(1);
            FFA_RD_IM1: rd_full = i_reg - NW'(1);
            FFA_RD_JM1: rd_full = j_reg - NW'(1);
            FFA_RD_JP1: rd_full = j_reg + NW'(1);
            default:    rd_full = i_reg;
        endcase
    end

    always_comb
    begin
        we      = 1'b1;
        wr_full = i_reg;
        wdata   = {cur_start_reg, cur_size_reg, 1'b0};
        if (init_we)
        begin
            we      = (bytes_sat > hdr);
            wr_full = '0;
            wdata   = {AW'(0), SW'(bytes_sat - hdr), 1'b0};
        end
        else
        begin
            case (cmd.wr_sel)
                FFA_WR_J:
                begin
                    wr_full = j_reg;
                    wdata   = rdata;
                end
                FFA_WR_SPLIT:
                begin
                    wr_full = i_reg + NW'(1);
                    wdata   = {AW'(CW'(cur_start_reg) + hdr + CW'(req_reg)),
                               SW'(CW'(cur_size_reg) - CW'(req_reg) - hdr), 1'b0};
                end
                FFA_WR_ALLOC:
                begin
                    wdata = {cur_start_reg, split ? SW'(req_reg) : cur_size_reg, 1'b1};
                end
                FFA_WR_FREE:
                begin
                    wdata = {cur_start_reg, cur_size_reg, 1'b0};
                end
                FFA_WR_PREV:
                begin
                    wr_full = i_reg - NW'(1);
                    wdata   = {nb_start_reg,
                               SW'(CW'(nb_size_reg) + hdr + CW'(cur_size_reg)), 1'b0};
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end
    end

    ffa_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (wr_full[IW-1:0]),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (rd_full[IW-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        cnt_next = cnt_reg;
        if (init_we)
        begin
            cnt_next = (bytes_sat > hdr) ? NW'(1) : NW'(0);
        end
        else if (cmd.wr_sel == FFA_WR_ALLOC && split)
        begin
            cnt_next = cnt_reg + NW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            cnt_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cfg_we && cfg_index == FFA_REG_POOL_BASE)
            begin
                base_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                i_reg <= '0;
            end
            else if (cmd.i_inc)
            begin
                i_reg <= i_reg + NW'(1);
            end
            case (cmd.j_op)
                FFA_J_CNT: j_reg <= cnt_reg;
                FFA_J_IP1: j_reg <= i_reg + NW'(1);
                FFA_J_I:   j_reg <= i_reg;
                FFA_J_DEC: j_reg <= j_reg - NW'(1);
                FFA_J_INC: j_reg <= j_reg + NW'(1);
                default:   j_reg <= j_reg;
            endcase
            if (cmd.done)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_mode;
            req_reg  <= in_req_size;
            off_reg  <= in_free_address - base_reg;
        end
        if (cmd.cap_cur)
        begin
            cur_start_reg <= r_start;
            cur_size_reg  <= r_size;
        end
        else if (cmd.merge)
        begin
            cur_size_reg <= SW'(CW'(cur_size_reg) + hdr + CW'(r_size));
        end
        if (cmd.cap_nb)
        begin
            nb_start_reg <= r_start;
            nb_size_reg  <= r_size;
        end
        if (cmd.done)
        begin
            res_st_reg   <= cmd.done_st;
            res_addr_reg <= (cmd.done_st == FFA_ST_OK && mode_reg == FFA_MODE_ALLOC)
                ? base_reg + FFA_ADDR_W'(cur_start_reg) + FFA_ADDR_W'(HEADER_BYTES)
                : '0;
        end
    end

    always_comb
    begin
        sts.mode       = mode_reg;
        sts.req_zero   = (req_reg == '0);
        sts.cnt_zero   = (cnt_reg == '0);
        if (mode_reg == FFA_MODE_ALLOC)
        begin
            sts.hit = !r_used && (CW'(r_size) >= CW'(req_reg));
        end
        else
        begin
            sts.hit = r_used && ((33'(r_start) + 33'(HEADER_BYTES)) == {1'b0, off_reg});
        end
        sts.split      = split;
        sts.i_last     = (i_reg + NW'(1)) >= cnt_reg;
        sts.i_gt0      = (i_reg != '0);
        sts.ip1_lt_cnt = (i_reg + NW'(1)) < cnt_reg;
        sts.j_gt_ip1   = j_reg > (i_reg + NW'(1));
        sts.jp1_lt_cnt = (j_reg + NW'(1)) < cnt_reg;
        sts.rd_free    = !r_used;
        sts.out_free   = !res_valid_reg || out_ready;
    end

    assign out_valid          = res_valid_reg;
    assign out_result_address = res_addr_reg;
    assign out_status         = res_st_reg;
endmodule
`default_nettype wire

FILE: sv/ffa_ctrl.sv
// Sequencer for scan, split-insert and free-merge of the segment table.
`timescale 1ns / 1ps
`default_nettype none
module ffa_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ffa_pkg::ffa_sts_t sts,
    output ffa_pkg::ffa_cmd_t      cmd
);
    import ffa_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHK   = 5'd1;
    localparam logic [4:0] S_SCAN  = 5'd2;
    localparam logic [4:0] S_A_DEC = 5'd3;
    localparam logic [4:0] S_A_SH  = 5'd4;
    localparam logic [4:0] S_A_SHW = 5'd5;
    localparam logic [4:0] S_A_SPL = 5'd6;
    localparam logic [4:0] S_A_USE = 5'd7;
    localparam logic [4:0] S_F_NXT = 5'd8;
    localparam logic [4:0] S_F_NCK = 5'd9;
    localparam logic [4:0] S_F_WRM = 5'd10;
    localparam logic [4:0] S_F_DR  = 5'd11;
    localparam logic [4:0] S_F_DRW = 5'd12;
    localparam logic [4:0] S_F_WRI = 5'd13;
    localparam logic [4:0] S_F_PRV = 5'd14;
    localparam logic [4:0] S_F_PCK = 5'd15;
    localparam logic [4:0] S_F_PWR = 5'd16;
    localparam logic [4:0] S_P_DR  = 5'd17;
    localparam logic [4:0] S_P_DRW = 5'd18;
    localparam logic [4:0] S_FIN   = 5'd19;

    logic [4:0]            state_reg, state_next;
    logic [FFA_STAT_W-1:0] fin_st_reg, fin_st_next;
    logic [FFA_STAT_W-1:0] miss_st;

    assign in_ready = (state_reg == S_IDLE);
    assign miss_st  = (sts.mode == FFA_MODE_ALLOC) ? FFA_ST_NO_FIT : FFA_ST_BAD_ADDR;

    always_comb
    begin
        state_next  = state_reg;
        fin_st_next = fin_st_reg;
        cmd         = '0;
        cmd.rd_sel  = FFA_RD_I;
        cmd.wr_sel  = FFA_WR_NONE;
        cmd.j_op    = FFA_J_HOLD;
        cmd.done_st = FFA_ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (sts.cnt_zero || (sts.mode == FFA_MODE_ALLOC && sts.req_zero))
                begin
                    fin_st_next = miss_st;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = FFA_RD_I;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.hit)
                begin
                    cmd.cap_cur = 1'b1;
                    state_next  = (sts.mode == FFA_MODE_ALLOC) ? S_A_DEC : S_F_NXT;
                end
                else if (sts.i_last)
                begin
                    fin_st_next = miss_st;
                    state_next  = S_FIN;
                end
                else
                begin
                    // read the next entry while advancing the index
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = FFA_RD_IP1;
                    cmd.i_inc  = 1'b1;
                end
            end
            S_A_DEC:
            begin
                if (sts.split)
                begin
                    cmd.j_op   = FFA_J_CNT;
                    state_next = S_A_SH;
                end
                else
                begin
                    cmd.wr_sel  = FFA_WR_ALLOC;
                    fin_st_next = FFA_ST_OK;
                    state_next  = S_FIN;
                end
            end
            S_A_SH:
            begin
                if (sts.j_gt_ip1)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = FFA_RD_JM1;
                    state_next = S_A_SHW;
                end
                else
                begin
                    state_next = S_A_SPL;
                end
            end
            S_A_SHW:
            begin
                cmd.wr_sel = FFA_WR_J;
                cmd.j_op   = FFA_J_DEC;
                state_next = S_A_SH;
            end
            S_A_SPL:
            begin
                cmd.wr_sel = FFA_WR_SPLIT;
                state_next = S_A_USE;
            end
            S_A_USE:
            begin
                cmd.wr_sel  = FFA_WR_ALLOC;
                fin_st_next = FFA_ST_OK;
                state_next  = S_FIN;
            end
            S_F_NXT:
            begin
                if (sts.ip1_lt_cnt)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = FFA_RD_IP1;
                    state_next = S_F_NCK;
                end
                else
                begin
                    state_next = S_F_WRI;
                end
            end
            S_F_NCK:
            begin
                if (sts.rd_free)
                begin
                    cmd.merge  = 1'b1;
                    cmd.j_op   = FFA_J_IP1;
                    state_next = S_F_WRM;
                end
                else
                begin
                    state_next = S_F_WRI;
                end
            end
            S_F_WRM:
            begin
                cmd.wr_sel = FFA_WR_FREE;
                state_next = S_F_DR;
            end
            S_F_DR:
            begin
                if (sts.jp1_lt_cnt)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = FFA_RD_JP1;
                    state_next = S_F_DRW;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_F_PRV;
                end
            end
            S_F_DRW:
            begin
                cmd.wr_sel = FFA_WR_J;
                cmd.j_op   = FFA_J_INC;
                state_next = S_F_DR;
            end
            S_F_WRI:
            begin
                cmd.wr_sel = FFA_WR_FREE;
                state_next = S_F_PRV;
            end
            S_F_PRV:
            begin
                if (sts.i_gt0)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = FFA_RD_IM1;
                    state_next = S_F_PCK;
                end
                else
                begin
                    fin_st_next = FFA_ST_OK;
                    state_next  = S_FIN;
                end
            end
            S_F_PCK:
            begin
                if (sts.rd_free)
                begin
                    cmd.cap_nb = 1'b1;
                    state_next = S_F_PWR;
                end
                else
                begin
                    fin_st_next = FFA_ST_OK;
                    state_next  = S_FIN;
                end
            end
            S_F_PWR:
            begin
                cmd.wr_sel = FFA_WR_PREV;
                cmd.j_op   = FFA_J_I;
                state_next = S_P_DR;
            end
            S_P_DR:
            begin
                if (sts.jp1_lt_cnt)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = FFA_RD_JP1;
                    state_next = S_P_DRW;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    fin_st_next = FFA_ST_OK;
                    state_next  = S_FIN;
                end
            end
            S_P_DRW:
            begin
                cmd.wr_sel = FFA_WR_J;
                cmd.j_op   = FFA_J_INC;
                state_next = S_P_DR;
            end
            S_FIN:
            begin
                // hold until the result register can take the transfer
                if (sts.out_free)
                begin
                    cmd.done    = 1'b1;
                    cmd.done_st = fin_st_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fin_st_reg <= FFA_ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            fin_st_reg <= fin_st_next;
        end
    end
endmodule
`default_nettype wire

FILE: sv/first_fit_block_allocator.sv
// Top level of the first-fit segment allocator with free-neighbor coalescing.
//
//  channel | dir | transfer when      | payload
//  req     | in  | valid && ready     | mode, req_size, free_address
//  rsp     | out | valid && ready     | result_address, status
//  cfg     | in  | valid && ready     | index (0 pool_base, 1 pool_bytes), data
//
// One request at a time: the scan reads one entry per cycle, and a split or a merge
// shifts each later entry with a read and then a write. Reset empties the table
// (no pool); cfg is always ready and a pool_bytes write rebuilds the pool. A held
// result does not stop the next request from being taken; only its completion
// waits for the result register.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_block_allocator #(
    parameter int MAX_SEGMENTS   = ffa_pkg::FFA_MAX_SEGMENTS,
    parameter int HEADER_BYTES   = ffa_pkg::FFA_HEADER_BYTES,
    parameter int POOL_ADDR_BITS = ffa_pkg::FFA_POOL_ADDR_BITS
) (
    input wire logic clk,
    input wire logic rst_n,
    ffa_req_if.sink  req,
    ffa_rsp_if.source rsp,
    ffa_cfg_if.sink  cfg
);
    import ffa_pkg::*;

    ffa_cmd_t cmd;
    ffa_sts_t sts;
    logic     cfg_we;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    ffa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffa_datapath #(
        .MAX_SEGMENTS   (MAX_SEGMENTS),
        .HEADER_BYTES   (HEADER_BYTES),
        .POOL_ADDR_BITS (POOL_ADDR_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_mode            (req.mode),
        .in_req_size        (req.req_size),
        .in_free_address    (req.free_address),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg.index),
        .cfg_data           (cfg.data),
        .cmd                (cmd),
        .sts                (sts),
        .out_valid          (rsp.valid),
        .out_ready          (rsp.ready),
        .out_result_address (rsp.result_address),
        .out_status         (rsp.status)
    );
endmodule
`default_nettype wire

FILE: bench/tb_first_fit_block_allocator.sv
// Self-checking testbench for the first-fit segment allocator.
`timescale 1ns / 1ps
`default_nettype none
module tb_first_fit_block_allocator;
    import ffa_pkg::*;

    localparam int MAX_SEG     = FFA_MAX_SEGMENTS;
    localparam int HDR         = FFA_HEADER_BYTES;
    localparam int POOL_LIMIT  = 1 << FFA_POOL_ADDR_BITS;
    localparam int SETTLE      = 250;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [FFA_ADDR_W-1:0] addr;
        logic [FFA_STAT_W-1:0] status;
    } alloc_result_t;

    logic clk;
    logic rst_n;

    ffa_req_if req_ch ();
    ffa_rsp_if rsp_ch ();
    ffa_cfg_if cfg_ch ();

    first_fit_block_allocator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow copy of the segment table
    int                    seg_start [MAX_SEG];
    int                    seg_size  [MAX_SEG];
    bit                    seg_used  [MAX_SEG];
    int                    seg_count;
    logic [FFA_ADDR_W-1:0] base_addr;
    int                    pool_len;

    alloc_result_t         pending_results [$];
    logic [FFA_ADDR_W-1:0] live_blocks [$];
    int                    error_count;
    int                    idle_pct;
    int                    stall_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
        error_count++;
    endtask

    function automatic void rebuild_pool(input logic [31:0] data);
        int bytes;
        bytes = int'(data[FFA_SIZE_W-1:0]);
        if (bytes > POOL_LIMIT)
            bytes = POOL_LIMIT;
        pool_len = bytes;
        if (bytes <= HDR)
        begin
            seg_count = 0;
            return;
        end
        seg_start[0] = 0;
        seg_size[0]  = bytes - HDR;
        seg_used[0]  = 1'b0;
        seg_count    = 1;
    endfunction

    function automatic void drop_segment(input int k);
        for (int j = k; j + 1 < seg_count; j++)
        begin
            seg_start[j] = seg_start[j+1];
            seg_size[j]  = seg_size[j+1];
            seg_used[j]  = seg_used[j+1];
        end
        seg_count--;
    endfunction

    function automatic alloc_result_t predict_alloc(input int want);
        alloc_result_t r;
        r.addr   = '0;
        r.status = FFA_ST_NO_FIT;
        if (want == 0)
            return r;
        for (int i = 0; i < seg_count; i++)
        begin
            if (seg_used[i] || seg_size[i] < want)
                continue;
            if (seg_size[i] > want + HDR && seg_count < MAX_SEG)
            begin
                for (int j = seg_count; j > i + 1; j--)
                begin
                    seg_start[j] = seg_start[j-1];
                    seg_size[j]  = seg_size[j-1];
                    seg_used[j]  = seg_used[j-1];
                end
                seg_start[i+1] = seg_start[i] + HDR + want;
                seg_size[i+1]  = seg_size[i] - want - HDR;
                seg_used[i+1]  = 1'b0;
                seg_size[i]    = want;
                seg_count++;
            end
            seg_used[i] = 1'b1;
            r.status    = FFA_ST_OK;
            r.addr      = base_addr + 32'(seg_start[i] + HDR);
            return r;
        end
        return r;
    endfunction

    function automatic alloc_result_t predict_free(input logic [31:0] addr);
        alloc_result_t r;
        logic [31:0]   offset;
        int            i;
        r.addr   = '0;
        r.status = FFA_ST_BAD_ADDR;
        offset   = addr - base_addr;
        for (i = 0; i < seg_count; i++)
            if (seg_used[i] && 32'(seg_start[i] + HDR) == offset)
                break;
        if (i >= seg_count)
            return r;
        seg_used[i] = 1'b0;
        if (i + 1 < seg_count && !seg_used[i+1])
        begin
            seg_size[i] = seg_size[i] + HDR + seg_size[i+1];
            drop_segment(i + 1);
        end
        if (i > 0 && !seg_used[i-1])
        begin
            seg_size[i-1] = seg_size[i-1] + HDR + seg_size[i];
            drop_segment(i);
        end
        r.status = FFA_ST_OK;
        return r;
    endfunction

    // Predict on every accepted request and register write
    always @(posedge clk)
    begin
        alloc_result_t r;
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
        begin
            if (cfg_ch.index == FFA_REG_POOL_BASE)
                base_addr = cfg_ch.data;
            else
            begin
                rebuild_pool(cfg_ch.data);
                live_blocks.delete();
            end
        end
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            if (req_ch.mode == FFA_MODE_ALLOC)
            begin
                r = predict_alloc(int'(req_ch.req_size));
                if (r.status == FFA_ST_OK)
                    live_blocks.push_back(r.addr);
            end
            else
            begin
                r = predict_free(req_ch.free_address);
                if (r.status == FFA_ST_OK)
                    foreach (live_blocks[k])
                        if (live_blocks[k] == req_ch.free_address)
                        begin
                            live_blocks.delete(k);
                            break;
                        end
            end
            pending_results.push_back(r);
        end
    end

    // Compare each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", {30'd0, rsp_ch.status}, 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.result_address !== want.addr)
                    report_mismatch("result_address", rsp_ch.result_address, want.addr);
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", {30'd0, rsp_ch.status}, {30'd0, want.status});
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic mode, input int want,
                                input logic [31:0] addr);
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= mode;
        req_ch.req_size     <= FFA_SIZE_W'(want);
        req_ch.free_address <= addr;
        do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        // let the last transfer reach the predictor first
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [FFA_CIDX_W-1:0] index, input logic [31:0] data);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic free_some_live();
        logic [31:0] a;
        a = live_blocks[$urandom_range(live_blocks.size() - 1)];
        send_request(FFA_MODE_FREE, $urandom, a);
    endtask

    task automatic test_no_pool();
        send_request(FFA_MODE_ALLOC, 5, 32'd0);
        send_request(FFA_MODE_FREE, 0, 32'(HDR));
        write_reg(FFA_REG_POOL_BYTES, 32'(HDR));
        send_request(FFA_MODE_ALLOC, 1, 32'd0);
        send_request(FFA_MODE_FREE, 0, 32'(HDR));
    endtask

    task automatic test_edge_cases();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        // one byte of payload
        write_reg(FFA_REG_POOL_BYTES, 32'(HDR + 1));
        send_request(FFA_MODE_ALLOC, 1, 32'd0);
        send_request(FFA_MODE_ALLOC, 1, 32'd0);
        send_request(FFA_MODE_FREE, 0, 32'(HDR));
        send_request(FFA_MODE_FREE, 0, 32'(HDR));
        // oversized pool saturates; base near the top wraps addresses
        write_reg(FFA_REG_POOL_BASE, 32'hFFFF_FFF0);
        write_reg(FFA_REG_POOL_BYTES, 32'hFFFF_FFFF);
        send_request(FFA_MODE_ALLOC, 0, 32'd0);
        send_request(FFA_MODE_ALLOC, POOL_LIMIT, 32'd0);
        send_request(FFA_MODE_ALLOC, (1 << FFA_SIZE_W) - 1, 32'd0);
        send_request(FFA_MODE_ALLOC, POOL_LIMIT - HDR, 32'd0);
        wait_drained();
        a = live_blocks[0];
        send_request(FFA_MODE_FREE, 0, a + 32'd1);
        send_request(FFA_MODE_FREE, 0, a);
        send_request(FFA_MODE_FREE, 0, a);
        send_request(FFA_MODE_FREE, 0, 32'hFFFF_FFFF);
        // split, then free middle to merge both sides
        send_request(FFA_MODE_ALLOC, 100, 32'd0);
        send_request(FFA_MODE_ALLOC, 200, 32'd0);
        send_request(FFA_MODE_ALLOC, 300, 32'd0);
        wait_drained();
        a = live_blocks[0];
        b = live_blocks[1];
        c = live_blocks[2];
        send_request(FFA_MODE_FREE, 0, a);
        send_request(FFA_MODE_FREE, 0, c);
        send_request(FFA_MODE_FREE, 0, b);
    endtask

    task automatic test_table_full();
        write_reg(FFA_REG_POOL_BASE, $urandom);
        write_reg(FFA_REG_POOL_BYTES, 32'(POOL_LIMIT));
        for (int n = 0; n < 70; n++)
            send_request(FFA_MODE_ALLOC, $urandom_range(1, 16), 32'd0);
        wait_drained();
        // free random live blocks to open holes in the table
        for (int n = 0; n < 20; n++)
            free_some_live();
        for (int n = 0; n < 20; n++)
            send_request(FFA_MODE_ALLOC, $urandom_range(1, 40), 32'd0);
        wait_drained();
        while (live_blocks.size() != 0)
        begin
            free_some_live();
            wait_drained();
        end
    endtask

    task automatic test_random_traffic(input int phases, input int per_phase);
        int sel;
        int want;
        for (int p = 0; p < phases; p++)
        begin
            write_reg(FFA_REG_POOL_BASE, ($urandom_range(3) == 0) ? 32'hFFFF_FF00 : $urandom);
            case ($urandom_range(4))
                0:       write_reg(FFA_REG_POOL_BYTES, 32'(POOL_LIMIT));
                1:       write_reg(FFA_REG_POOL_BYTES, $urandom_range(HDR + 1, 600));
                2:       write_reg(FFA_REG_POOL_BYTES, $urandom_range(0, HDR + 40));
                default: write_reg(FFA_REG_POOL_BYTES, 32'({$urandom_range(2047), 21'h0}
                                                       | $urandom_range(1 << FFA_SIZE_W)));
            endcase
            idle_pct = (p == 1) ? 0 : 17;
            for (int n = 0; n < per_phase; n++)
            begin
                if (p == 2 && n == per_phase / 2)
                    wait_drained();
                sel = $urandom_range(99);
                if (sel < 55)
                begin
                    if ($urandom_range(99) < 75)
                        want = $urandom_range(1, 64);
                    else if ($urandom_range(99) < 85)
                        want = $urandom_range(0, (pool_len > 0) ? pool_len : 1);
                    else
                        want = $urandom_range(0, (1 << FFA_SIZE_W) - 1);
                    send_request(FFA_MODE_ALLOC, want, $urandom);
                end
                else if (sel < 90 && live_blocks.size() != 0)
                    free_some_live();
                else if (sel < 95 && live_blocks.size() != 0)
                    send_request(FFA_MODE_FREE, $urandom,
                                 live_blocks[0] + 32'($urandom_range(1, 3)));
                else
                    send_request(FFA_MODE_FREE, $urandom, $urandom);
            end
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.mode         = FFA_MODE_ALLOC;
        req_ch.req_size     = '0;
        req_ch.free_address = '0;
        rsp_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = FFA_REG_POOL_BASE;
        cfg_ch.data         = '0;
        error_count         = 0;
        idle_pct            = 17;
        stall_cycles        = 0;
        base_addr           = '0;
        pool_len            = 0;
        seg_count           = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_pool();
        test_edge_cases();
        test_table_full();
        test_random_traffic(6, 110);

        wait_drained();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
